// ===== hdl/gfl_pkg.sv =====
// Package with shared types and constants for the greedy facility location block.
package gfl_pkg;

  localparam int COST_W = 40;
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_ROUND,
    ST_TRIAL,
    ST_TERM,
    ST_TERM_WAIT,
    ST_TRIAL_END,
    ST_UPD,
    ST_UPD_WAIT,
    ST_ROUND_END,
    ST_DONE
  } gfl_state_t;

  typedef struct packed {
    logic load;
    logic clr;
    logic round_init;
    logic trial_init;
    logic term_issue;
    logic term_acc;
    logic trial_close;
    logic open_pick;
    logic upd_issue;
    logic upd_write;
    logic round_close;
    logic done;
  } gfl_cmd_t;

  typedef struct packed {
    logic i_last;
    logic i_skip;
    logic j_last;
    logic t_last;
  } gfl_sts_t;

endpackage

// ===== hdl/gfl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module gfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/gfl_datapath.sv =====
// Datapath: site stores, trial cost accumulation, round minimum and best service update.
module gfl_datapath
  import gfl_pkg::*;
#(
  parameter int MAX_SITES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  gfl_cmd_t    cmd,
  input  logic [15:0] in_position,
  input  logic [15:0] in_demand_weight,
  input  logic [31:0] in_opening_cost,
  input  logic [6:0]  cfg_k,
  output gfl_sts_t    sts,
  output logic [COST_W-1:0] min_cost,
  output logic [6:0]  best_round
);
  localparam int AW = $clog2(MAX_SITES);
  localparam int CW = $clog2(MAX_SITES + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] i_r, j_r, pick_r;
  logic [6:0]    t_r, kk_r;
  logic [MAX_SITES-1:0] opened_r;
  logic [COST_W-1:0] sum_r, rmin_r, runmin_r;
  logic          found_r;
  logic [6:0]    bround_r;
  logic [AW-1:0] rd_j_r;
  logic          rd_jeq_r;

  logic [15:0] pos_j, wgt_j, pos_i_r;
  logic [31:0] oc_j, bsc_j;
  logic [AW-1:0] raddr;
  logic [15:0] pos_rd;
  logic        ram_we;
  logic [AW-1:0] ram_wa;
  logic          take_i;
  logic [AW-1:0] pick_now;

  assign ram_we = cmd.load && (cnt_r < CW'(MAX_SITES));
  assign ram_wa = cnt_r[AW-1:0];
  assign raddr  = (cmd.round_init || cmd.trial_init) ? i_r : j_r;

  assign take_i   = !opened_r[i_r] && (!found_r || sum_r < rmin_r);
  assign pick_now = take_i ? i_r : pick_r;

  gfl_ram #(.WIDTH(16), .DEPTH(MAX_SITES)) u_pos (
    .clk, .we(ram_we), .waddr(ram_wa), .wdata(in_position), .raddr(raddr), .rdata(pos_rd));
  gfl_ram #(.WIDTH(16), .DEPTH(MAX_SITES)) u_wgt (
    .clk, .we(ram_we), .waddr(ram_wa), .wdata(in_demand_weight), .raddr(raddr), .rdata(wgt_j));
  gfl_ram #(.WIDTH(32), .DEPTH(MAX_SITES)) u_oc (
    .clk, .we(ram_we), .waddr(ram_wa), .wdata(in_opening_cost), .raddr(raddr), .rdata(oc_j));

  logic [31:0] dist_j;
  logic [15:0] d16;
  logic [31:0] term;
  logic [AW-1:0] bsc_wa;
  logic [31:0] bsc_wd;
  logic [COST_W:0] add_full;

  assign pos_j = pos_rd;
  assign d16 = (pos_j > pos_i_r) ? (pos_j - pos_i_r) : (pos_i_r - pos_j);
  assign dist_j = 32'(d16) * 32'(wgt_j);
  assign bsc_wa = rd_j_r;
  assign bsc_wd = opened_r[rd_j_r] ? 32'd0 :
                  ((t_r == 7'd1 || dist_j < bsc_j) ? dist_j : bsc_j);

  gfl_ram #(.WIDTH(32), .DEPTH(MAX_SITES)) u_bsc (
    .clk, .we(cmd.upd_write), .waddr(bsc_wa), .wdata(bsc_wd), .raddr(raddr), .rdata(bsc_j));

  always_comb begin
    if (opened_r[rd_j_r] || rd_jeq_r) begin
      term = oc_j;
    end else if (t_r != 7'd1 && bsc_j < dist_j) begin
      term = bsc_j;
    end else begin
      term = dist_j;
    end
  end
  assign add_full = {1'b0, sum_r} + {9'd0, term};

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clr) begin
      cnt_nxt = '0;
    end else if (ram_we) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      opened_r <= '0;
      runmin_r <= COST_MAX;
      bround_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.load && (cnt_r < CW'(MAX_SITES))) begin
        opened_r[cnt_r[AW-1:0]] <= 1'b0;
      end
      if (cmd.open_pick) begin
        opened_r[pick_now] <= 1'b1;
      end
      if (cmd.round_close) begin
        if (bround_r == 7'd0 || rmin_r < runmin_r) begin
          runmin_r <= rmin_r;
          bround_r <= t_r;
        end
      end
      if (cmd.clr) begin
        opened_r <= '0;
        runmin_r <= COST_MAX;
        bround_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r  <= 7'd1;
      i_r  <= '0;
      j_r  <= '0;
    end
    if (cmd.round_init) begin
      kk_r    <= (cfg_k == 7'd0) ? 7'd1 :
                 ((32'(cfg_k) > 32'(cnt_r)) ? 7'(cnt_r) : cfg_k);
      i_r     <= '0;
      found_r <= 1'b0;
      rmin_r  <= COST_MAX;
      pick_r  <= '0;
    end
    if (cmd.trial_init) begin
      j_r   <= '0;
      sum_r <= '0;
    end
    if (cmd.term_issue) begin
      rd_j_r   <= j_r;
      rd_jeq_r <= (j_r == i_r);
      if (j_r == '0) begin
        pos_i_r <= pos_rd;
      end
      j_r <= j_r + AW'(1);
    end
    if (cmd.term_acc) begin
      sum_r <= add_full[COST_W] ? COST_MAX : add_full[COST_W-1:0];
    end
    if (cmd.trial_close) begin
      if (take_i) begin
        found_r <= 1'b1;
        rmin_r  <= sum_r;
        pick_r  <= i_r;
      end
      i_r <= i_r + AW'(1);
      j_r <= '0;
    end
    if (cmd.open_pick) begin
      i_r <= pick_now;
      j_r <= '0;
    end
    if (cmd.upd_issue) begin
      rd_j_r <= j_r;
      if (j_r == '0) begin
        pos_i_r <= pos_rd;
      end
      j_r <= j_r + AW'(1);
    end
    if (cmd.round_close) begin
      t_r <= t_r + 7'd1;
      i_r <= '0;
      j_r <= '0;
      found_r <= 1'b0;
      rmin_r  <= COST_MAX;
    end
  end

  assign sts.i_last = (CW'(i_r) + CW'(1) >= cnt_r);
  assign sts.i_skip = opened_r[i_r];
  assign sts.j_last = (CW'(rd_j_r) + CW'(1) >= cnt_r);
  assign sts.t_last = (t_r >= kk_r);
  assign min_cost   = runmin_r;
  assign best_round = bround_r;
endmodule

// ===== hdl/gfl_ctrl.sv =====
// Controller state machine sequencing loading, greedy rounds and result output.
module gfl_ctrl
  import gfl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_last_site,
  input  gfl_sts_t sts,
  output gfl_cmd_t cmd,
  output logic     busy
);
  gfl_state_t state_r, state_nxt;
  logic upd_first_r, upd_first_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      upd_first_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      upd_first_r <= upd_first_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    upd_first_nxt = upd_first_r;
    cmd           = '0;
    busy          = (state_r != ST_LOAD);
    case (state_r)
      ST_LOAD: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_last_site) begin
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        cmd.round_init = 1'b1;
        state_nxt = ST_TRIAL;
      end
      ST_TRIAL: begin
        if (sts.i_skip) begin
          state_nxt = ST_TRIAL_END;
        end else begin
          cmd.trial_init = 1'b1;
          state_nxt = ST_TERM;
        end
      end
      ST_TERM: begin
        cmd.term_issue = 1'b1;
        state_nxt = ST_TERM_WAIT;
      end
      ST_TERM_WAIT: begin
        cmd.term_acc = 1'b1;
        state_nxt = sts.j_last ? ST_TRIAL_END : ST_TERM;
        if (!sts.j_last) begin
          cmd.term_issue = 1'b1;
          state_nxt = ST_TERM_WAIT;
        end
      end
      ST_TRIAL_END: begin
        cmd.trial_close = 1'b1;
        state_nxt = sts.i_last ? ST_UPD : ST_TRIAL;
        if (sts.i_last) begin
          cmd.open_pick = 1'b1;
        end
        upd_first_nxt = 1'b1;
      end
      ST_UPD: begin
        if (upd_first_r) begin
          cmd.trial_init = 1'b1;
          upd_first_nxt = 1'b0;
        end else begin
          cmd.upd_issue = 1'b1;
          state_nxt = ST_UPD_WAIT;
        end
      end
      ST_UPD_WAIT: begin
        cmd.upd_write = 1'b1;
        if (sts.j_last) begin
          state_nxt = ST_ROUND_END;
        end else begin
          cmd.upd_issue = 1'b1;
        end
      end
      ST_ROUND_END: begin
        cmd.round_close = 1'b1;
        state_nxt = sts.t_last ? ST_DONE : ST_TRIAL;
      end
      ST_DONE: begin
        cmd.done = 1'b1;
        cmd.clr  = 1'b1;
        state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  a_done_from_round: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> $past(state_r) == ST_ROUND_END) else $error("bad done entry");
  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy) else $error("load while busy");
  a_write_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_write |-> $past(cmd.upd_issue)) else $error("write without read");
endmodule

// ===== hdl/greedy_facility_location_line_top.sv =====
// Top level of the greedy facility location block on a line.
// Sites load one beat per cycle while busy is low. The beat marked last_site starts the
// greedy placement over K rounds on the N stored sites. In a round each closed site runs
// its trial, one term per cycle through the registered site memories, each open site is
// skipped, and the best service update then runs over all N sites. The single result
// beat appears on out_valid in the cycle after the controller's done state. The receiver
// cannot stall; busy falls in the same cycle that the result beat is shown.
module greedy_facility_location_line_top
  import gfl_pkg::*;
#(
  parameter int MAX_SITES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_position,
  input  logic [15:0] in_demand_weight,
  input  logic [31:0] in_opening_cost,
  input  logic        in_last_site,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  output logic        out_valid,
  output logic [39:0] out_min_total_cost,
  output logic [6:0]  out_facilities_used
);
  gfl_cmd_t cmd;
  gfl_sts_t sts;
  logic [6:0] cfg_k_r;
  logic [COST_W-1:0] min_cost;
  logic [6:0] best_round;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_k_r <= 7'd1;
    end else if (cfg_we) begin
      cfg_k_r <= cfg_wdata;
    end
  end

  gfl_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_last_site, .sts, .cmd, .busy);

  gfl_datapath #(.MAX_SITES(MAX_SITES)) u_dp (
    .clk, .rst_n, .cmd, .in_position, .in_demand_weight, .in_opening_cost,
    .cfg_k(cfg_k_r), .sts, .min_cost, .best_round);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.done;
    end
    if (cmd.done) begin
      out_min_total_cost  <= min_cost;
      out_facilities_used <= best_round;
    end
  end
endmodule
